// ===== rtl/core/lfsta_pkg.sv =====
// ----------------------------------------------------------------------------
// lfsta_pkg
// shared types for the lowest free slot timed allocator
// ----------------------------------------------------------------------------
package lfsta_pkg;

  localparam int TIME_W = 16;
  localparam int SLOT_W = 6;

  typedef struct packed {
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] departure;
    logic              is_target;
  } lfsta_in_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              none_free;
    logic              target_echo;
  } lfsta_out_t;

  // request moving along the row of slot cells
  typedef struct packed {
    logic              valid;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] departure;
    logic              is_target;
    logic              found;
    logic [SLOT_W-1:0] slot;
  } lfsta_tok_t;

endpackage

// ===== rtl/core/lfsta_cell.sv =====
// ----------------------------------------------------------------------------
// lfsta_cell
// one slot: holds its release time, grants a passing request if free
// ----------------------------------------------------------------------------
module lfsta_cell #(
  parameter int IDX = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               adv,
  input  lfsta_pkg::lfsta_tok_t tok_in,
  output lfsta_pkg::lfsta_tok_t tok_out
);
  import lfsta_pkg::*;

  localparam logic [SLOT_W-1:0] CELL_SLOT = SLOT_W'(IDX);

  logic [TIME_W-1:0] rel_r;
  logic              vld_r;
  lfsta_tok_t        tok_r;
  lfsta_tok_t        tok_nxt;
  logic              take;

  assign take = tok_in.valid && !tok_in.found && (rel_r <= tok_in.arrival);

  always_comb begin
    tok_nxt = tok_in;
    if (take) begin
      tok_nxt.found = 1'b1;
      tok_nxt.slot  = CELL_SLOT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_r <= '0;
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= tok_in.valid;
      if (take) begin
        rel_r <= tok_in.departure;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tok_r <= tok_nxt;
    end
  end

  always_comb begin
    tok_out       = tok_r;
    tok_out.valid = vld_r;
  end

endmodule

// ===== rtl/core/lowest_free_slot_timed_allocator.sv =====
// an accepted item is registered in each slot cell in turn up to its result
// throughput: one item per cycle, set by the NUM_SLOTS slot cells, if not held
// each cell is one stage; a request passes every cell in slot order
// the whole row holds while a result waits on out_stall
// reset clears every release time to zero (all slots free) and drops
// every item in flight
// ----------------------------------------------------------------------------
// lowest_free_slot_timed_allocator
// grants each request the lowest slot whose release time is at or before
// its arrival, then sets that slot's release time to the departure
// ----------------------------------------------------------------------------
module lowest_free_slot_timed_allocator #(
  parameter int NUM_SLOTS = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  lfsta_pkg::lfsta_in_t   in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output lfsta_pkg::lfsta_out_t  out_data
);
  import lfsta_pkg::*;

  lfsta_tok_t tok [0:NUM_SLOTS];
  logic       adv;

  assign adv      = !tok[NUM_SLOTS].valid || !out_stall;
  assign in_stall = !adv;

  always_comb begin
    tok[0].valid     = in_valid;
    tok[0].arrival   = in_data.arrival;
    tok[0].departure = in_data.departure;
    tok[0].is_target = in_data.is_target;
    tok[0].found     = 1'b0;
    tok[0].slot      = '0;
  end

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    lfsta_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  assign out_valid            = tok[NUM_SLOTS].valid;
  assign out_data.slot        = tok[NUM_SLOTS].slot;
  assign out_data.none_free   = !tok[NUM_SLOTS].found;
  assign out_data.target_echo = tok[NUM_SLOTS].is_target;

endmodule

// ===== rtl/core/lfsta_checker.sv =====
// ----------------------------------------------------------------------------
// lfsta_checker
// port level checks for the lowest free slot timed allocator
// ----------------------------------------------------------------------------
module lfsta_checker (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input lfsta_pkg::lfsta_in_t  in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input lfsta_pkg::lfsta_out_t out_data
);
  import lfsta_pkg::*;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // no free slot means slot zero
  a_none_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.none_free |-> out_data.slot == '0)
    else $error("slot nonzero with none_free");

  // a blocked result holds the input side
  a_hold_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result blocked");

  // blocked result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("blocked result changed");

  // stalled item stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled item changed");

endmodule

bind lowest_free_slot_timed_allocator lfsta_checker u_lfsta_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/tb_lowest_free_slot_timed_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lowest_free_slot_timed_allocator
// Sends timed slot requests under changing sender idle and receiver stall.
// A scoreboard keeps its own table of slot release times and predicts each
// grant. It checks every result in order, field by field.
// ----------------------------------------------------------------------------
module tb_lowest_free_slot_timed_allocator;
  import lfsta_pkg::*;

  localparam int NUM_SLOTS    = 64;
  localparam int RANDOM_ITEMS = 500;
  localparam int WRAP_ITEMS   = 40;

  typedef enum int {
    PH_STEADY,
    PH_SENDER_IDLE,
    PH_RECV_STALL,
    PH_BOTH_IDLE
  } idle_phase_e;

  class slot_scoreboard;
    logic [TIME_W-1:0] release_at [NUM_SLOTS];
    lfsta_out_t        grants_due [$];
    int                n_errors;
    int                n_checked;
    int                n_none_free;
    int                n_targets;

    function new();
      foreach (release_at[i]) release_at[i] = '0;
      n_errors    = 0;
      n_checked   = 0;
      n_none_free = 0;
      n_targets   = 0;
    endfunction

    function void note_request(lfsta_in_t req);
      lfsta_out_t grant;
      grant             = '0;
      grant.none_free   = 1'b1;
      grant.target_echo = req.is_target;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (release_at[i] <= req.arrival) begin
          release_at[i]   = req.departure;
          grant.slot      = SLOT_W'(i);
          grant.none_free = 1'b0;
          break;
        end
      end
      grants_due.push_back(grant);
    endfunction

    function void check_result(lfsta_out_t got);
      lfsta_out_t want;
      if (grants_due.size() == 0) begin
        $error("unexpected result: slot %0d none_free %0b target_echo %0b",
               got.slot, got.none_free, got.target_echo);
        n_errors++;
      end else begin
        want = grants_due.pop_front();
        n_checked++;
        if (want.none_free) n_none_free++;
        if (want.target_echo) n_targets++;
        if (got.slot !== want.slot) begin
          $error("slot: expected %0d, got %0d", want.slot, got.slot);
          n_errors++;
        end
        if (got.none_free !== want.none_free) begin
          $error("none_free: expected %0b, got %0b", want.none_free, got.none_free);
          n_errors++;
        end
        if (got.target_echo !== want.target_echo) begin
          $error("target_echo: expected %0b, got %0b", want.target_echo, got.target_echo);
          n_errors++;
        end
      end
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  lfsta_in_t  in_data   = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  lfsta_out_t out_data;

  int sender_idle_pct = 0;
  int recv_stall_pct  = 0;

  slot_scoreboard sb;

  lowest_free_slot_timed_allocator #(
    .NUM_SLOTS(NUM_SLOTS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  function automatic void set_phase(idle_phase_e ph);
    case (ph)
      PH_STEADY: begin
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
      end
      PH_SENDER_IDLE: begin
        sender_idle_pct = 82;
        recv_stall_pct  = 0;
      end
      PH_RECV_STALL: begin
        sender_idle_pct = 0;
        recv_stall_pct  = 82;
      end
      default: begin
        sender_idle_pct = 37;
        recv_stall_pct  = 37;
      end
    endcase
  endfunction

  task automatic request(input logic [TIME_W-1:0] arr, input logic [TIME_W-1:0] dep,
                         input logic tgt);
    lfsta_in_t req;
    req.arrival   = arr;
    req.departure = dep;
    req.is_target = tgt;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_request(req);
    @(negedge clk);
  endtask

  initial begin : stimulus
    logic [TIME_W-1:0] now;
    int                step_pick [5] = '{0, 1, 2, 8, 40};
    int                stay_pick [4] = '{1, 16, 200, 1500};
    int                n_directed;
    int                n_sent;
    int                seq_idx;
    int                seq_len;
    int                step_max;
    int                stay_max;
    int                tgt_at;
    int                k;

    sb = new();
    set_phase(PH_STEADY);
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // extremes, departure before arrival, out of order arrivals
    request(16'h0000, 16'h0000, 1'b0);
    request(16'h0000, 16'hFFFF, 1'b1);
    request(16'hFFFF, 16'h0000, 1'b0);
    request(16'h5555, 16'hAAAA, 1'b1);
    request(16'hAAAA, 16'h5555, 1'b0);
    request(16'h5554, 16'h6000, 1'b1);
    request(16'h5555, 16'h5556, 1'b0);
    request(16'h5555, 16'h7000, 1'b1);
    for (k = 0; k < 5; k++) request(16'h7000, 16'h7001, k[0]);
    request(16'h7001, 16'h7001, 1'b1);
    n_directed = 14;

    // mostly ordered bursts with a stray request now and then
    now     = 16'h7100;
    n_sent  = 0;
    seq_idx = 0;
    while (n_sent < RANDOM_ITEMS) begin
      set_phase(idle_phase_e'(seq_idx % 4));
      seq_len  = $urandom_range(72, 16);
      step_max = step_pick[$urandom_range(4)];
      stay_max = stay_pick[$urandom_range(3)];
      tgt_at   = $urandom_range(seq_len - 1);
      for (k = 0; k < seq_len; k++) begin
        if ($urandom_range(99) < 12) begin
          request(16'($urandom), ($urandom_range(3) == 0) ? 16'($urandom) : now,
                  1'($urandom));
        end else begin
          request(now, now + 16'($urandom_range(stay_max, 1)), k == tgt_at);
          now += 16'($urandom_range(step_max));
        end
        n_sent++;
      end
      now += 16'($urandom_range(400));
      seq_idx++;
    end

    // arrival ticks wrapping past the top of the time range
    set_phase(PH_BOTH_IDLE);
    now = 16'hFFC0;
    for (k = 0; k < WRAP_ITEMS; k++) begin
      request(now, now + 16'($urandom_range(120, 1)), 1'($urandom));
      now += 16'($urandom_range(3));
    end
    in_valid <= 1'b0;

    while (sb.grants_due.size() != 0) @(posedge clk);
    repeat (NUM_SLOTS + 16) @(posedge clk);

    $display("ran %0d requests: %0d directed, %0d in random bursts, %0d across time wrap",
             sb.n_checked, n_directed, n_sent, WRAP_ITEMS);
    $display("%0d grants found every slot busy, %0d carried a target mark",
             sb.n_none_free, sb.n_targets);
    if (sb.n_errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end

endmodule

// ===== lowest_free_slot_timed_allocator.f =====
rtl/core/lfsta_pkg.sv
rtl/core/lfsta_cell.sv
rtl/core/lowest_free_slot_timed_allocator.sv
rtl/core/lfsta_checker.sv
tb/tb_lowest_free_slot_timed_allocator.sv
